// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held
`define ALID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs during reset
`define ALID_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/alid_pkg.sv -----
// Types, codes and constants of the ordered word list block.
package alid_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 6;
    localparam int OP_W      = 3;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_VIEW   = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Input beat
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] target;
        logic                     after;
    } t_item;

    // Output beat
    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] data;
        t_pos                     position;
        logic                     last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRD,
        S_SCMP,
        S_IS_CHK,
        S_IS_WR,
        S_DS_CHK,
        S_DS_WR,
        S_VRD,
        S_VRES,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_DEC,
        RD_IDX_INC
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_IDX_RD,
        WR_POS_VALUE,
        WR_CNT_VALUE
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_COUNT,
        RES_POS,
        RES_VIEW
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_idx_op  idx_op;
        logic     pos_load;
        t_cnt_op  cnt_op;
        logic     res_load;
        t_status  res_status;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            match;
        logic            idx_last;
        logic            ins_more;
        logic            del_more;
        logic            res_last;
        logic            slot_free;
    } t_dp_sts;

endpackage

// ----- rtl/core/alid_datapath.sv -----
// List datapath: entry memory, count, scan index, result staging and output register.
module alid_datapath
    import alid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_in_data,
    input  logic    i_out_ready,
    input  t_cmd    i_cmd,
    output t_dp_sts o_sts,
    output logic    o_out_valid,
    output t_result o_out_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] mem [DEPTH];

    t_item                    r_item;
    logic signed [WORD_W-1:0] r_rd;
    logic [IW-1:0]            r_idx;
    logic [IW-1:0]            r_pos;
    logic [CW-1:0]            r_count;
    t_result                  r_res;
    logic                     r_out_valid;
    t_result                  r_out;

    logic [CW-1:0]            idx_ext;
    logic [CW-1:0]            idx_inc_ext;
    logic signed [WORD_W-1:0] key;
    logic                     ins_after;
    logic [IW-1:0]            rd_addr;
    logic [IW-1:0]            wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    // Status toward the controller
    assign idx_ext     = CW'(r_idx);
    assign idx_inc_ext = idx_ext + CW'(1);
    assign key         = (r_item.op == OP_INSERT) ? r_item.target : r_item.value;
    assign ins_after   = (r_item.op == OP_INSERT) && r_item.after;

    assign o_sts.op        = r_item.op;
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.match     = (r_rd == key);
    assign o_sts.idx_last  = (idx_inc_ext == r_count);
    assign o_sts.ins_more  = (r_idx > r_pos);
    assign o_sts.del_more  = (idx_inc_ext < r_count);
    assign o_sts.res_last  = r_res.last;
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    // Memory address and data selection
    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_DEC: rd_addr = r_idx - IW'(1);
            RD_IDX_INC: rd_addr = r_idx + IW'(1);
            default:    rd_addr = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_POS_VALUE: begin
                wr_addr = r_pos;
                wr_data = r_item.value;
            end
            WR_CNT_VALUE: begin
                wr_addr = r_count[IW-1:0];
                wr_data = r_item.value;
            end
            default: begin
                wr_addr = r_idx;
                wr_data = r_rd;
            end
        endcase
    end

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
    end

    // Scan index and found position
    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IDX_ZERO:  r_idx <= '0;
            IDX_INC:   r_idx <= r_idx + IW'(1);
            IDX_DEC:   r_idx <= r_idx - IW'(1);
            IDX_COUNT: r_idx <= r_count[IW-1:0];
            default:   r_idx <= r_idx;
        endcase
        if (i_cmd.pos_load) begin
            r_pos <= r_idx + IW'(ins_after);
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_ZERO: r_count <= '0;
                CNT_INC:  r_count <= r_count + CW'(1);
                CNT_DEC:  r_count <= r_count - CW'(1);
                default:  r_count <= r_count;
            endcase
        end
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res.status <= i_cmd.res_status;
            case (i_cmd.res_sel)
                RES_COUNT: begin
                    r_res.data     <= '0;
                    r_res.position <= t_pos'(r_count[IW-1:0]);
                    r_res.last     <= 1'b1;
                end
                RES_POS: begin
                    r_res.data     <= '0;
                    r_res.position <= t_pos'(r_pos);
                    r_res.last     <= 1'b1;
                end
                RES_VIEW: begin
                    r_res.data     <= r_rd;
                    r_res.position <= t_pos'(r_idx);
                    r_res.last     <= o_sts.idx_last;
                end
                default: begin
                    r_res.data     <= '0;
                    r_res.position <= '0;
                    r_res.last     <= 1'b1;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/alid_ctrl.sv -----
// List controller: sequences search, shift, view and result beats.
module alid_ctrl
    import alid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_CLEAR, OP_APPEND: n_state = S_EMIT;
                    OP_VIEW:   n_state = i_sts.empty ? S_EMIT : S_VRD;
                    OP_INSERT: n_state = (i_sts.full || i_sts.empty) ? S_EMIT : S_SRD;
                    OP_DELETE: n_state = i_sts.empty ? S_EMIT : S_SRD;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SRD: n_state = S_SCMP;
            S_SCMP: begin
                if (i_sts.match) begin
                    n_state = (i_sts.op == OP_INSERT) ? S_IS_CHK : S_DS_CHK;
                end else if (i_sts.idx_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_IS_CHK: n_state = i_sts.ins_more ? S_IS_WR : S_EMIT;
            S_IS_WR:  n_state = S_IS_CHK;
            S_DS_CHK: n_state = i_sts.del_more ? S_DS_WR : S_EMIT;
            S_DS_WR:  n_state = S_DS_CHK;
            S_VRD:    n_state = S_VRES;
            S_VRES:   n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.res_last ? S_IDLE : S_VRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load_item  = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = RD_IDX;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = WR_IDX_RD;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.pos_load   = 1'b0;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.res_load   = 1'b0;
        o_cmd.res_status = ST_OK;
        o_cmd.res_sel    = RES_PLAIN;
        o_cmd.out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_CLEAR: begin
                        o_cmd.cnt_op   = CNT_ZERO;
                        o_cmd.res_load = 1'b1;
                    end
                    OP_APPEND: begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = WR_CNT_VALUE;
                            o_cmd.cnt_op  = CNT_INC;
                            o_cmd.res_sel = RES_COUNT;
                        end
                    end
                    OP_VIEW: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                        end
                    end
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_NOT_FOUND;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                        end
                    end
                    default: ;
                endcase
            end
            S_SRD, S_VRD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_SCMP: begin
                // Insert shifts from the top down, delete from the hit upward
                if (i_sts.match) begin
                    o_cmd.pos_load = 1'b1;
                    if (i_sts.op == OP_INSERT) begin
                        o_cmd.idx_op = IDX_COUNT;
                    end
                end else if (i_sts.idx_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_IS_CHK: begin
                if (i_sts.ins_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_DEC;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = WR_POS_VALUE;
                    o_cmd.cnt_op   = CNT_INC;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_POS;
                end
            end
            S_IS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_DEC;
            end
            S_DS_CHK: begin
                if (i_sts.del_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_INC;
                end else begin
                    o_cmd.cnt_op   = CNT_DEC;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_POS;
                end
            end
            S_DS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_INC;
            end
            S_VRES: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_VIEW;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    if (!i_sts.res_last) begin
                        o_cmd.idx_op = IDX_INC;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/array_list_insert_delete.sv -----
// Ordered list of up to DEPTH signed words with clear, append, insert, delete and view.
// Each input beat carries one operation and is taken only while the block is idle; an
// item runs to completion before the next is accepted. The entries live in a memory with
// one write port and a registered read port, so every stored entry touched takes a read,
// then a compare or a write back. Clear, append and every early status (full, empty) go
// straight from decode to the result beat. Insert and delete scan from the first entry for
// the first match of the word and then shift entries to open or close a slot; when the word
// is absent from the list, every entry is scanned before the not-found result. View emits
// one beat per entry, and the next entry is read only once the output register takes a beat.
// The output register lets a result wait for the sink while the controller goes on to the
// next step. No clearing pass is needed after reset.
module array_list_insert_delete
    import alid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    t_cmd    cmd;
    t_dp_sts sts;

    alid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    alid_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/alid_checker.sv -----
// Port-level checks for the list block, bound to its top level.
`include "assert_macros.svh"

module alid_checker
    import alid_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_ready,
    input t_item   i_in_data,
    input logic    o_out_valid,
    input logic    i_out_ready,
    input t_result o_out_data
);

    // A stalled result beat holds
    `ALID_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // Reset leaves no result pending
    `ALID_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // Any status other than ok is a single closing beat with zero data and position
    `ALID_ASSERT(a_err_beat, o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.last && (o_out_data.data == 0) && (o_out_data.position == 0), "bad error beat")

    // No new item is taken in the middle of a view stream
    `ALID_ASSERT(a_view_busy, o_out_valid && !o_out_data.last |-> !o_in_ready, "input ready during view stream")

endmodule

bind array_list_insert_delete alid_checker u_alid_checker (.*);
